@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RXD_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rxd check failed");

// Antecedent must be followed by consequent on the same edge.
`define RXD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rxd check failed");

`endif

@@ hdl/rxd_pkg.sv @@
// Package for the rolling XOR head/tail decryptor: types and register map.
`timescale 1ns / 1ps
`default_nettype none

package rxd_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned LenW   = 32;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned KeyNum = 4;
  localparam int unsigned KeyIdxW = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned BusW   = 32;

  typedef enum logic [1:0] {
    REG_SEED      = 2'd0,
    REG_KEY_STEP  = 2'd1,
    REG_BLOCK_LEN = 2'd2,
    REG_ENABLE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SeedW-1:0] seed;
    logic [7:0]       key_step;
    logic [LenW-1:0]  block_len;
    logic             encrypt_enable;
  } cfg_t;

  // One classified request on its way from front to back.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             first;
    logic             decrypt;
  } req_t;

endpackage

`default_nettype wire

@@ hdl/rxd_front.sv @@
// Front end: tracks file position and length, classifies each byte.
`timescale 1ns / 1ps
`default_nettype none

module rxd_front import rxd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [DataW-1:0] data_byte,
  input  wire logic             first_byte,
  input  wire logic [LenW-1:0]  file_length,
  input  wire cfg_t             cfg,
  output req_t                  req
);

  logic [LenW-1:0] byte_position;
  logic [LenW-1:0] current_length;
  logic [LenW-1:0] pos;
  logic [LenW-1:0] len;
  logic            in_head;
  logic            below_len;
  logic            tail_on;
  logic            in_tail;

  always_comb begin
    pos       = first_byte ? '0 : byte_position;
    len       = first_byte ? file_length : current_length;
    below_len = pos < len;
    in_head   = pos < cfg.block_len;
    tail_on   = {1'b0, len} > {cfg.block_len, 1'b0};
    in_tail   = ({1'b0, pos} + {1'b0, cfg.block_len}) >= {1'b0, len};
    req.data    = data_byte;
    req.first   = first_byte;
    req.decrypt = cfg.encrypt_enable && below_len && (in_head || (tail_on && in_tail));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      current_length <= '0;
    end else if (push) begin
      current_length <= len;
      byte_position  <= (pos == '1) ? pos : pos + 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rxd_fifo.sv @@
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module rxd_fifo import rxd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_req,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output req_t      pop_req
);

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign pop_req = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/rxd_back.sv @@
// Back end: rotating key bytes, XOR, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rxd_back import rxd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_avail,
  input  wire req_t             req,
  output logic                  pop,
  input  wire cfg_t             cfg,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [DataW-1:0]      out_byte,
  output logic                  was_decrypted
);

  logic [7:0]         key_bytes [KeyNum];
  logic [KeyIdxW-1:0] key_index;
  logic [7:0]         cur_key [KeyNum];
  logic [KeyIdxW-1:0] cur_idx;
  logic [7:0]         key_next [KeyNum];
  logic [KeyIdxW-1:0] key_index_next;
  logic [7:0]         step;

  assign pop  = req_avail && (!result_valid || result_ready);
  assign step = (cfg.key_step == '0) ? 8'd1 : cfg.key_step;

  always_comb begin
    for (int i = 0; i < KeyNum; i++) begin
      cur_key[i] = req.first ? cfg.seed[8*i +: 8] : key_bytes[i];
    end
    cur_idx = req.first ? '0 : key_index;
    for (int i = 0; i < KeyNum; i++) begin
      key_next[i] = cur_key[i];
    end
    key_index_next = cur_idx;
    if (req.decrypt) begin
      key_next[cur_idx] = cur_key[cur_idx] + step;
      key_index_next    = cur_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyNum; i++) begin
        key_bytes[i] <= '0;
      end
      key_index <= '0;
    end else if (pop) begin
      for (int i = 0; i < KeyNum; i++) begin
        key_bytes[i] <= key_next[i];
      end
      key_index <= key_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte      <= req.decrypt ? (req.data ^ cur_key[cur_idx]) : req.data;
      was_decrypted <= req.decrypt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rolling_xor_head_tail_decrypt.sv @@
// Top level: configuration registers, front end, request queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte per clock while the queue has room and returns one byte per
// clock while the receiver holds result_ready high; a result is presented once
// its byte has passed through a queue entry and the result register. The front
// compares position against file length and block_len combinationally, the
// back applies the rotating key, and a two-entry queue lets input keep flowing
// while a result waits; input stalls only once both queue entries are taken.
// Registers: 0x0 seed, 0x4 key_step, 0x8 block_len, 0xC encrypt_enable.
module rolling_xor_head_tail_decrypt import rxd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             data_valid,
  output logic                  data_ready,
  input  wire logic [DataW-1:0] data_byte,
  input  wire logic             first_byte,
  input  wire logic [LenW-1:0]  file_length,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [DataW-1:0]      out_byte,
  output logic                  was_decrypted,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [BusW-1:0]  pwdata,
  output logic [BusW-1:0]       prdata,
  output logic                  pready
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  req_t     front_req;
  req_t     queue_req;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed           <= '0;
      cfg.key_step       <= 8'd1;
      cfg.block_len      <= '0;
      cfg.encrypt_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SEED:      cfg.seed           <= pwdata;
        REG_KEY_STEP:  cfg.key_step       <= pwdata[7:0];
        REG_BLOCK_LEN: cfg.block_len      <= pwdata;
        REG_ENABLE:    cfg.encrypt_enable <= pwdata[0];
        default:       cfg                <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SEED:      prdata = cfg.seed;
      REG_KEY_STEP:  prdata = {24'd0, cfg.key_step};
      REG_BLOCK_LEN: prdata = cfg.block_len;
      REG_ENABLE:    prdata = {31'd0, cfg.encrypt_enable};
      default:       prdata = '0;
    endcase
  end

  assign data_ready = !full;
  assign push       = data_valid && data_ready;

  rxd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .file_length (file_length),
    .cfg         (cfg),
    .req         (front_req)
  );

  rxd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (front_req),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_req  (queue_req)
  );

  rxd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .req_avail     (!empty),
    .req           (queue_req),
    .pop           (pop),
    .cfg           (cfg),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .out_byte      (out_byte),
    .was_decrypted (was_decrypted)
  );

endmodule

`default_nettype wire

@@ hdl/rxd_checker.sv @@
// Port-level checker for the decryptor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rxd_checker import rxd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             data_valid,
  input wire logic             data_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire logic [DataW-1:0] out_byte,
  input wire logic             was_decrypted,
  input wire logic             pready
);

  logic           res_stall;
  logic           res_rise;
  logic           acc_two_ago;
  logic           in_acc;
  logic           in_acc_d1;
  logic           in_acc_d2;
  logic           rst_d;
  logic           res_valid_d;
  logic           res_ready_d;
  logic [DataW:0] res_word;

  assign in_acc   = data_valid && data_ready;
  assign res_word = {out_byte, was_decrypted};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_acc_d1 <= 1'b0;
      in_acc_d2 <= 1'b0;
    end else begin
      in_acc_d1 <= in_acc;
      in_acc_d2 <= in_acc_d1;
    end
  end

  always_ff @(posedge clk) begin
    rst_d       <= rst;
    res_valid_d <= result_valid;
    res_ready_d <= result_ready;
  end

  assign res_stall   = res_valid_d && !res_ready_d && !rst_d;
  assign res_rise    = result_valid && !res_valid_d && !rst_d;
  assign acc_two_ago = in_acc_d2;

  `RXD_ASSERT_ALWAYS(a_pready_high, clk, rst, pready)
  `RXD_ASSERT_IMPLY(a_result_hold, clk, rst, res_stall, result_valid)
  `RXD_ASSERT_IMPLY(a_result_stable, clk, rst, res_stall, $stable(res_word))
  `RXD_ASSERT_IMPLY(a_result_latency, clk, rst, res_rise, acc_two_ago)

endmodule

bind rolling_xor_head_tail_decrypt rxd_checker u_rxd_checker (
  .clk           (clk),
  .rst           (rst),
  .data_valid    (data_valid),
  .data_ready    (data_ready),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .out_byte      (out_byte),
  .was_decrypted (was_decrypted),
  .pready        (pready)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the rolling XOR head/tail decryptor.
`timescale 1ns / 1ps

module tb_top;
  import rxd_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] out_byte;
    logic             decrypted;
  } dec_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             data_valid = 1'b0;
  logic             data_ready;
  logic [DataW-1:0] data_byte = '0;
  logic             first_byte = 1'b0;
  logic [LenW-1:0]  file_length = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [DataW-1:0] out_byte;
  logic             was_decrypted;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [BusW-1:0]  pwdata = '0;
  logic [BusW-1:0]  prdata;
  logic             pready;

  rolling_xor_head_tail_decrypt u_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .file_length  (file_length),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .was_decrypted(was_decrypted),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // Shadow of the decryptor: registers and key state.
  cfg_t              shadow_cfg = '{seed: '0, key_step: 8'd1, block_len: '0,
                                    encrypt_enable: 1'b1};
  logic [7:0]        key_ring [KeyNum];
  logic [KeyIdxW-1:0] key_ptr = '0;
  logic [LenW-1:0]   byte_pos = '0;
  logic [LenW-1:0]   cur_len = '0;

  dec_result_t       expected_bytes [$];
  dec_result_t       want;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       errors = 0;
  int unsigned       n_sent = 0;
  int unsigned       n_files = 0;
  int unsigned       n_decrypted = 0;
  int unsigned       n_reg_writes = 0;

  initial begin
    for (int i = 0; i < KeyNum; i++) key_ring[i] = 8'h00;
  end

  task automatic flag_error(string what, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    if (errors <= 10)
      $display("ERROR at %0t: %s expected %h got %h", $time, what, want_v, got_v);
  endtask

  function automatic logic in_crypt_region(logic [LenW-1:0] p);
    logic [33:0] len34;
    logic [33:0] blk34;
    len34 = {2'b00, cur_len};
    blk34 = {2'b00, shadow_cfg.block_len};
    if (p >= cur_len) return 1'b0;
    if (p < shadow_cfg.block_len) return 1'b1;
    return (len34 > (blk34 << 1)) && (p >= cur_len - shadow_cfg.block_len);
  endfunction

  task automatic decrypt_predict(logic [7:0] d, logic f, logic [LenW-1:0] len);
    dec_result_t r;
    logic [7:0]  stp;
    if (f) begin
      cur_len  = len;
      byte_pos = '0;
      key_ptr  = '0;
      for (int i = 0; i < KeyNum; i++) key_ring[i] = shadow_cfg.seed[8*i +: 8];
    end
    r.out_byte  = d;
    r.decrypted = 1'b0;
    if (shadow_cfg.encrypt_enable && in_crypt_region(byte_pos)) begin
      stp = (shadow_cfg.key_step == 8'd0) ? 8'd1 : shadow_cfg.key_step;
      r.out_byte = d ^ key_ring[key_ptr];
      key_ring[key_ptr] = key_ring[key_ptr] + stp;
      key_ptr = key_ptr + 1'b1;
      r.decrypted = 1'b1;
      n_decrypted++;
    end
    if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
    expected_bytes.insert(expected_bytes.size(), r);
  endtask

  task automatic send_req(logic [7:0] d, logic f, logic [LenW-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid  <= 1'b1;
    data_byte   <= d;
    first_byte  <= f;
    file_length <= len;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    n_sent++;
    decrypt_predict(d, f, len);
  endtask

  task automatic send_file(logic [LenW-1:0] flen, int unsigned nbytes);
    n_files++;
    for (int unsigned i = 0; i < nbytes; i++)
      send_req(8'($urandom), i == 0, (i == 0) ? flen : $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    data_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    logic [31:0] mask;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    n_reg_writes++;
    case (idx)
      REG_SEED:      begin shadow_cfg.seed = val; mask = 32'hFFFF_FFFF; end
      REG_KEY_STEP:  begin shadow_cfg.key_step = val[7:0]; mask = 32'h0000_00FF; end
      REG_BLOCK_LEN: begin shadow_cfg.block_len = val; mask = 32'hFFFF_FFFF; end
      default:       begin shadow_cfg.encrypt_enable = val[0]; mask = 32'h0000_0001; end
    endcase
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) != (val & mask)) flag_error("register readback", val & mask, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_bytes.size() == 0) begin
        flag_error("unexpected result byte", 32'd0, 32'(out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.out_byte)
          flag_error("out_byte", 32'(want.out_byte), 32'(out_byte));
        if (was_decrypted !== want.decrypted)
          flag_error("was_decrypted", 32'(want.decrypted), 32'(was_decrypted));
      end
    end
  end

  // No file started since reset: length is zero, bytes pass.
  task automatic test_no_file();
    send_req(8'h00, 1'b0, 32'hFFFF_FFFF);
    send_req(8'hFF, 1'b0, 32'h0000_0000);
    drain();
  endtask

  // Head and tail both decrypted, step of zero, tail key continues from head.
  task automatic test_head_tail();
    write_reg(REG_SEED, 32'hFF00_A55A);
    write_reg(REG_KEY_STEP, 32'd0);
    write_reg(REG_BLOCK_LEN, 32'd3);
    send_file(32'd8, 0);
    for (int i = 0; i < 8; i++) send_req((i % 2) ? 8'hFF : 8'h00, i == 0, 32'd8);
    drain();
  endtask

  // Short file, bytes past the end, and an empty file.
  task automatic test_short_and_empty();
    write_reg(REG_KEY_STEP, 32'd255);
    n_files++;
    for (int i = 0; i < 7; i++) send_req(8'(8'h3C + i), i == 0, 32'd5);
    send_file(32'd0, 1);
    drain();
  endtask

  // Register changes inside a file: enable off then on, seed held until next file.
  task automatic test_midfile_writes();
    write_reg(REG_BLOCK_LEN, 32'd10);
    send_file(32'd6, 1);
    drain();
    write_reg(REG_ENABLE, 32'd0);
    send_req(8'h81, 1'b0, 32'd0);
    drain();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_SEED, 32'h1234_5678);
    write_reg(REG_KEY_STEP, 32'd7);
    send_req(8'h7E, 1'b0, 32'd0);
    send_req(8'hE7, 1'b0, 32'd0);
    drain();
  endtask

  // Lengths near the top of the 32-bit range.
  task automatic test_wide_lengths();
    write_reg(REG_BLOCK_LEN, 32'hFFFF_FFFF);
    send_file(32'hFFFF_FFFF, 1);
    drain();
    write_reg(REG_BLOCK_LEN, 32'h7FFF_FFFF);
    send_file(32'hFFFF_FFFF, 2);
    drain();
  endtask

  task automatic test_random_files();
    int unsigned target;
    int unsigned flen;
    int unsigned nbytes;
    int unsigned r;
    int unsigned cap;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      drain();
      case (seg)
        0: begin
          write_reg(REG_SEED, 32'hFFFF_FFFF);
          write_reg(REG_KEY_STEP, 32'd255);
          write_reg(REG_BLOCK_LEN, 32'd0);
          write_reg(REG_ENABLE, 32'd1);
        end
        1: begin
          write_reg(REG_SEED, 32'd0);
          write_reg(REG_KEY_STEP, 32'd0);
          write_reg(REG_BLOCK_LEN, 32'd5);
        end
        default: begin
          r = $urandom_range(9);
          write_reg(REG_SEED, (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom);
          r = $urandom_range(9);
          write_reg(REG_KEY_STEP, (r == 0) ? 32'd0 : (r == 1) ? 32'd255 :
                    $urandom_range(255));
          r = $urandom_range(19);
          write_reg(REG_BLOCK_LEN, (r < 2) ? 32'd0 : (r == 2) ? 32'hFFFF_FFFF :
                    (r == 3) ? $urandom : $urandom_range(1, 12));
          write_reg(REG_ENABLE, 32'($urandom_range(4) != 0));
        end
      endcase
      target = n_sent + 185;
      while (n_sent < target) begin
        r   = $urandom_range(99);
        cap = (shadow_cfg.block_len > 12) ? 12 : shadow_cfg.block_len;
        if (r < 80) begin
          flen   = $urandom_range(2 * cap + 8);
          nbytes = flen;
          if ($urandom_range(9) == 0) nbytes = flen + $urandom_range(1, 4);
          else if ($urandom_range(19) == 0) nbytes = flen / 2;
          if (nbytes == 0) nbytes = 1;
          send_file(flen, nbytes);
        end else if (r < 90) begin
          send_file($urandom, $urandom_range(1, 24));
        end else begin
          nbytes = $urandom_range(1, 10);
          for (int unsigned i = 0; i < nbytes; i++)
            send_req(8'($urandom), $urandom_range(3) == 0, $urandom);
        end
        if ($urandom_range(49) == 0) drain();
      end
    end
  endtask

  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_no_file();
    test_head_tail();
    test_short_and_empty();
    test_midfile_writes();
    test_wide_lengths();
    test_random_files();
    drain();
    repeat (10) @(posedge clk);
    if (expected_bytes.size() != 0)
      flag_error("results never returned", 32'(expected_bytes.size()), 32'd0);
    $display("Run covered %0d requests in %0d files, %0d of them decrypted.",
             n_sent, n_files, n_decrypted);
    $display("Register writes: %0d; mismatches: %0d.", n_reg_writes, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rxd_pkg.sv
hdl/rxd_front.sv
hdl/rxd_fifo.sv
hdl/rxd_back.sv
hdl/rolling_xor_head_tail_decrypt.sv
hdl/rxd_checker.sv
sim/tb_top.sv
